@@ hdl/strm_pkg.sv @@
// Shared types, constants and font tables for the scrolling text matrix renderer.
package strm_pkg;

   // Geometry of the matrix and of the font
   localparam int MATRIX_COLS = 32;
   localparam int MATRIX_ROWS = 7;
   localparam int CHAR_PITCH  = 6;
   localparam int GLYPH_COLS  = 5;
   localparam int MAX_CHARS   = 15;

   // Derived widths
   localparam int CHAR_W  = 8;
   localparam int LEN_W   = 4;
   localparam int POS_W   = 8;
   localparam int CH_W    = $clog2(MAX_CHARS + 1);
   localparam int SUB_W   = $clog2(CHAR_PITCH + 1);
   localparam int IDX_W   = $clog2(MAX_CHARS * CHAR_PITCH + 1);
   localparam int SUM_W   = POS_W + 2;
   localparam int GLYPH_W = 5;

   // Reciprocal of the pitch, used to split a text column into character and sub-column
   localparam int RECIP_SHIFT = 12;
   localparam int RECIP       = (1 << RECIP_SHIFT) / CHAR_PITCH + 1;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int PROD_W      = IDX_W + RECIP_W;

   // Reset value of the restart offset
   localparam logic signed [POS_W-1:0] RESTART_RESET = -8'sd13;
   localparam logic [CHAR_W-1:0]       DEGREE_CODE   = 8'hB0;

   // Rows that exist on the matrix, bit six is the top row
   localparam logic [6:0] ROW_MASK = 7'h7F << (7 - MATRIX_ROWS);

   // Operation codes
   typedef enum logic [3:0] {
      OP_STAGE   = 4'd0,
      OP_SET_RST = 4'd1,
      OP_SET_KEEP= 4'd2,
      OP_TEST_ON = 4'd3,
      OP_TEST_OFF= 4'd4,
      OP_TICK    = 4'd5,
      OP_ENABLE  = 4'd6,
      OP_SAVE    = 4'd7,
      OP_RESTORE = 4'd8,
      OP_OFFSET  = 4'd9,
      OP_READ    = 4'd10
   } op_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic divide;
      logic fetch;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_read;
   } dp_status_type;

   // Map a character byte to its glyph; bytes without a glyph show glyph zero.
   function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CHAR_W-1:0] code);
      logic [GLYPH_W-1:0] g;
      begin
         g = '0;
         if (code >= 8'h30 && code <= 8'h39) begin
            g = GLYPH_W'(code - 8'h30);
         end else begin
            case (code)
               8'h3A:       g = 5'd10;
               8'h2E:       g = 5'd11;
               DEGREE_CODE: g = 5'd12;
               8'h4E:       g = 5'd13;
               8'h53:       g = 5'd14;
               8'h45:       g = 5'd15;
               8'h57:       g = 5'd16;
               8'h20:       g = 5'd17;
               8'h44:       g = 5'd18;
               8'h59:       g = 5'd19;
               8'h41:       g = 5'd20;
               8'h54:       g = 5'd21;
               8'h43:       g = 5'd22;
               8'h48:       g = 5'd23;
               8'h56:       g = 5'd24;
               8'h4C:       g = 5'd25;
               default:     g = '0;
            endcase
         end
         return g;
      end
   endfunction

   // Font ROM: five columns of seven rows, first column in the top bits.
   function automatic logic [34:0] glyph_rom(input logic [GLYPH_W-1:0] g);
      logic [34:0] r;
      begin
         case (g)
            5'd0:    r = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
            5'd1:    r = {7'h00, 7'h21, 7'h7F, 7'h01, 7'h00};
            5'd2:    r = {7'h23, 7'h45, 7'h49, 7'h51, 7'h22};
            5'd3:    r = {7'h22, 7'h41, 7'h49, 7'h49, 7'h36};
            5'd4:    r = {7'h0C, 7'h14, 7'h24, 7'h7F, 7'h04};
            5'd5:    r = {7'h72, 7'h51, 7'h51, 7'h51, 7'h4E};
            5'd6:    r = {7'h3E, 7'h49, 7'h49, 7'h49, 7'h06};
            5'd7:    r = {7'h40, 7'h40, 7'h47, 7'h48, 7'h70};
            5'd8:    r = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
            5'd9:    r = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
            5'd10:   r = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
            5'd11:   r = {7'h00, 7'h00, 7'h08, 7'h00, 7'h00};
            5'd12:   r = {7'h30, 7'h48, 7'h48, 7'h30, 7'h00};
            5'd13:   r = {7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F};
            5'd14:   r = {7'h32, 7'h49, 7'h49, 7'h49, 7'h26};
            5'd15:   r = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
            5'd16:   r = {7'h7E, 7'h01, 7'h1E, 7'h01, 7'h7E};
            5'd17:   r = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
            5'd18:   r = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
            5'd19:   r = {7'h40, 7'h20, 7'h1F, 7'h20, 7'h40};
            5'd20:   r = {7'h1F, 7'h24, 7'h44, 7'h24, 7'h1F};
            5'd21:   r = {7'h40, 7'h40, 7'h7F, 7'h40, 7'h40};
            5'd22:   r = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
            5'd23:   r = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
            5'd24:   r = {7'h7C, 7'h02, 7'h01, 7'h02, 7'h7C};
            5'd25:   r = {7'h7F, 7'h01, 7'h01, 7'h01, 7'h02};
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

@@ hdl/strm_ctrl.sv @@
// Controller state machine that sequences one operation through the datapath.
module strm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  strm_pkg::dp_status_type status,
   output logic                   busy,
   output logic                   rsp_valid,
   output strm_pkg::ctrl_cmd_type cmd
);
   import strm_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_FETCH  = 5'b01000,
      ST_REPLY  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state: pixel reads take the divide and fetch steps, all else replies at once.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.is_read ? ST_DIVIDE : ST_REPLY;
         end
         ST_DIVIDE: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands and handshake outputs decoded from the state.
   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && start;
      cmd.exec   = (state_ff == ST_EXEC);
      cmd.divide = (state_ff == ST_DIVIDE);
      cmd.fetch  = (state_ff == ST_FETCH);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_REPLY);

endmodule

@@ hdl/strm_datapath.sv @@
// Datapath holding the text buffers, scroll state and the pixel lookup steps.
module strm_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  strm_pkg::ctrl_cmd_type        cmd,
   output strm_pkg::dp_status_type       status,
   input  logic [3:0]                    req_operation,
   input  logic [3:0]                    req_char_pos,
   input  logic [7:0]                    req_char_code,
   input  logic [3:0]                    req_text_length,
   input  logic                          req_enable_value,
   input  logic signed [7:0]             req_offset_value,
   input  logic [7:0]                    req_pixel_row,
   input  logic [7:0]                    req_pixel_col,
   input  logic                          csr_we,
   input  logic signed [7:0]             csr_wdata,
   output logic                          rsp_pixel_on,
   output logic [6:0]                    rsp_column_bits,
   output logic                          rsp_scroll_on,
   output logic                          rsp_test_on,
   output logic signed [7:0]             rsp_position,
   output logic [3:0]                    rsp_shown_length
);
   import strm_pkg::*;

   // Latched request word
   op_type                   op_ff;
   logic [3:0]               char_pos_ff;
   logic [CHAR_W-1:0]        char_code_ff;
   logic [LEN_W-1:0]         text_length_ff;
   logic                     enable_ff;
   logic signed [POS_W-1:0]  offset_ff;
   logic [7:0]               row_ff;
   logic [7:0]               col_ff;

   // Text buffers
   logic [CHAR_W-1:0] shown_ff  [MAX_CHARS];
   logic [CHAR_W-1:0] staged_ff [MAX_CHARS];
   logic [CHAR_W-1:0] kept_ff   [MAX_CHARS];
   logic [CHAR_W-1:0] shown_in  [MAX_CHARS];
   logic [CHAR_W-1:0] kept_in   [MAX_CHARS];

   // Scroll state
   logic signed [POS_W-1:0] restart_ff;
   logic [LEN_W-1:0]        shown_len_ff, shown_len_in;
   logic [LEN_W-1:0]        kept_len_ff, kept_len_in;
   logic signed [POS_W-1:0] scroll_pos_ff, scroll_pos_in;
   logic                    scroll_flag_ff, scroll_flag_in;
   logic                    test_flag_ff, test_flag_in;
   logic signed [POS_W-1:0] saved_pos_ff, saved_pos_in;
   logic                    saved_scroll_ff, saved_scroll_in;

   // Pixel lookup pipeline
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             hit_ff, hit_in;
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic [SUB_W-1:0] sub_ff, sub_in;
   logic             hit2_ff, hit2_in;
   logic [6:0]       colbits_ff, colbits_in;
   logic             pixel_ff, pixel_in;

   // Helper values
   logic [LEN_W-1:0]        commit_len;
   logic signed [SUM_W-1:0] span;
   logic signed [SUM_W-1:0] next_pos;
   logic signed [SUM_W-1:0] text_idx;
   logic [PROD_W-1:0]       prod;
   logic [CH_W-1:0]         quot;
   logic [IDX_W:0]          quot_pitch;
   logic [IDX_W:0]          rem;
   logic [CHAR_W-1:0]       sel_code;
   logic [34:0]             glyph_bits;
   logic [6:0]              col_rows;
   logic [2:0]              bit_sel;

   assign status.is_read = (op_ff == OP_READ);

   // Request capture when a word is accepted.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff          <= op_type'(req_operation);
         char_pos_ff    <= req_char_pos;
         char_code_ff   <= req_char_code;
         text_length_ff <= req_text_length;
         enable_ff      <= req_enable_value;
         offset_ff      <= req_offset_value;
         row_ff         <= req_pixel_row;
         col_ff         <= req_pixel_col;
      end
   end

   // Committed length is cut to the buffer depth; span is the text width in columns.
   assign commit_len = (text_length_ff > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS)
                                                            : text_length_ff;
   assign span       = SUM_W'(shown_len_ff) * SUM_W'(CHAR_PITCH);
   assign next_pos   = SUM_W'(scroll_pos_ff) + SUM_W'(1);

   // Operation decode: next value of the scroll state and the text buffers.
   always_comb begin
      shown_len_in    = shown_len_ff;
      kept_len_in     = kept_len_ff;
      scroll_pos_in   = scroll_pos_ff;
      scroll_flag_in  = scroll_flag_ff;
      test_flag_in    = test_flag_ff;
      saved_pos_in    = saved_pos_ff;
      saved_scroll_in = saved_scroll_ff;
      shown_in        = shown_ff;
      kept_in         = kept_ff;
      case (op_ff)
         OP_SET_RST: begin
            shown_in     = staged_ff;
            shown_len_in = commit_len;
            if (commit_len != '0) begin
               scroll_flag_in = 1'b1;
               scroll_pos_in  = restart_ff;
            end
         end
         OP_SET_KEEP: begin
            shown_in     = staged_ff;
            shown_len_in = commit_len;
         end
         OP_TEST_ON: begin
            kept_in        = shown_ff;
            kept_len_in    = shown_len_ff;
            shown_in       = staged_ff;
            shown_len_in   = commit_len;
            test_flag_in   = 1'b1;
            scroll_flag_in = 1'b1;
            scroll_pos_in  = restart_ff;
         end
         OP_TEST_OFF: begin
            if (test_flag_ff) begin
               test_flag_in = 1'b0;
               if (kept_len_ff != '0) begin
                  shown_in      = kept_ff;
                  shown_len_in  = kept_len_ff;
                  scroll_pos_in = restart_ff;
               end
            end
         end
         OP_TICK: begin
            if (shown_len_ff != '0 && scroll_flag_ff) begin
               if (next_pos >= span) begin
                  scroll_pos_in = restart_ff;
                  if (test_flag_ff) begin
                     test_flag_in = 1'b0;
                     if (kept_len_ff != '0) begin
                        shown_in     = kept_ff;
                        shown_len_in = kept_len_ff;
                     end
                  end
               end else if (next_pos > SUM_W'(127)) begin
                  scroll_pos_in = 8'sd127;
               end else begin
                  scroll_pos_in = next_pos[POS_W-1:0];
               end
            end
         end
         OP_ENABLE: begin
            scroll_flag_in = enable_ff;
         end
         OP_SAVE: begin
            saved_pos_in    = scroll_pos_ff;
            saved_scroll_in = scroll_flag_ff;
         end
         OP_RESTORE: begin
            scroll_pos_in  = saved_pos_ff;
            scroll_flag_in = saved_scroll_ff;
         end
         OP_OFFSET: begin
            scroll_pos_in = offset_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers and the restart offset register.
   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff      <= RESTART_RESET;
         shown_len_ff    <= '0;
         kept_len_ff     <= '0;
         scroll_pos_ff   <= RESTART_RESET;
         scroll_flag_ff  <= 1'b0;
         test_flag_ff    <= 1'b0;
         saved_pos_ff    <= '0;
         saved_scroll_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            restart_ff <= csr_wdata;
         end
         if (cmd.exec) begin
            shown_len_ff    <= shown_len_in;
            kept_len_ff     <= kept_len_in;
            scroll_pos_ff   <= scroll_pos_in;
            scroll_flag_ff  <= scroll_flag_in;
            test_flag_ff    <= test_flag_in;
            saved_pos_ff    <= saved_pos_in;
            saved_scroll_ff <= saved_scroll_in;
         end
      end
   end

   // Text buffers carry no reset; entries are undefined until written.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         shown_ff <= shown_in;
         kept_ff  <= kept_in;
         if (op_ff == OP_STAGE && char_pos_ff < 4'(MAX_CHARS)) begin
            staged_ff[char_pos_ff] <= char_code_ff;
         end
      end
   end

   // First lookup step: text column of the requested display column and range check.
   assign text_idx = SUM_W'(scroll_pos_ff) + SUM_W'($unsigned({1'b0, col_ff}));

   always_comb begin
      hit_in = ({1'b0, col_ff} < 9'(MATRIX_COLS)) && (shown_len_ff != '0) &&
               (text_idx >= SUM_W'(0)) && (text_idx < span);
      idx_in = text_idx[IDX_W-1:0];
   end

   // Second step: character and sub-column by reciprocal multiply with one correction.
   assign prod       = PROD_W'(idx_ff) * PROD_W'(RECIP);
   assign quot       = prod[RECIP_SHIFT +: CH_W];
   assign quot_pitch = (IDX_W+1)'(quot) * (IDX_W+1)'(CHAR_PITCH);
   assign rem        = {1'b0, idx_ff} - quot_pitch;

   always_comb begin
      if (rem >= (IDX_W+1)'(CHAR_PITCH)) begin
         ch_in  = quot + CH_W'(1);
         sub_in = SUB_W'(rem - (IDX_W+1)'(CHAR_PITCH));
      end else begin
         ch_in  = quot;
         sub_in = SUB_W'(rem);
      end
      hit2_in = hit_ff && (sub_in < SUB_W'(GLYPH_COLS)) && (ch_in < CH_W'(MAX_CHARS));
   end

   // Third step: character lookup, font column and the requested row.
   always_comb begin
      sel_code   = (ch_ff < CH_W'(MAX_CHARS)) ? shown_ff[ch_ff] : '0;
      glyph_bits = glyph_rom(glyph_of(sel_code));
      col_rows   = glyph_bits[34 - 7 * sub_ff -: 7] & ROW_MASK;
      colbits_in = hit2_ff ? col_rows : 7'h00;
      bit_sel    = 3'd6 - row_ff[2:0];
      pixel_in   = (row_ff < 8'(MATRIX_ROWS)) && ({1'b0, col_ff} < 9'(MATRIX_COLS)) &&
                   colbits_in[bit_sel];
   end

   // Lookup pipeline registers; results read as zero for all other operations.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         idx_ff     <= idx_in;
         hit_ff     <= hit_in;
         colbits_ff <= 7'h00;
         pixel_ff   <= 1'b0;
      end
      if (cmd.divide) begin
         ch_ff   <= ch_in;
         sub_ff  <= sub_in;
         hit2_ff <= hit2_in;
      end
      if (cmd.fetch) begin
         colbits_ff <= colbits_in;
         pixel_ff   <= pixel_in;
      end
   end

   // Result word
   assign rsp_pixel_on     = pixel_ff;
   assign rsp_column_bits  = colbits_ff;
   assign rsp_scroll_on    = scroll_flag_ff;
   assign rsp_test_on      = test_flag_ff;
   assign rsp_position     = scroll_pos_ff;
   assign rsp_shown_length = shown_len_ff;

endmodule

@@ hdl/scrolling_text_matrix_renderer_top.sv @@
// Top level of the scrolling text matrix renderer: controller plus datapath.
// A result word is strobed in the reply state, after decode, or after decode, divide and
// font lookup for a pixel read. The controller takes a new word only while idle and steps
// one word at a time through these steps.
// Results cannot be stalled: each is shown for exactly one cycle.
// Synchronous active-high reset clears the text lengths, flags and saved state and sets
// the restart offset and scroll position to -13; text buffers are not cleared.
module scrolling_text_matrix_renderer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [3:0]        req_operation,
   input  logic [3:0]        req_char_pos,
   input  logic [7:0]        req_char_code,
   input  logic [3:0]        req_text_length,
   input  logic              req_enable_value,
   input  logic signed [7:0] req_offset_value,
   input  logic [7:0]        req_pixel_row,
   input  logic [7:0]        req_pixel_col,
   output logic              rsp_valid,
   output logic              rsp_pixel_on,
   output logic [6:0]        rsp_column_bits,
   output logic              rsp_scroll_on,
   output logic              rsp_test_on,
   output logic signed [7:0] rsp_position,
   output logic [3:0]        rsp_shown_length,
   input  logic              csr_we,
   input  logic signed [7:0] csr_wdata
);
   import strm_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer
   strm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // State and pixel lookup
   strm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_char_pos     (req_char_pos),
      .req_char_code    (req_char_code),
      .req_text_length  (req_text_length),
      .req_enable_value (req_enable_value),
      .req_offset_value (req_offset_value),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_pixel_on     (rsp_pixel_on),
      .rsp_column_bits  (rsp_column_bits),
      .rsp_scroll_on    (rsp_scroll_on),
      .rsp_test_on      (rsp_test_on),
      .rsp_position     (rsp_position),
      .rsp_shown_length (rsp_shown_length)
   );

endmodule

@@ hdl/strm_checker.sv @@
// Port-level checker for the scrolling text matrix renderer, with its bind statement.
module strm_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic              rsp_pixel_on,
   input logic [6:0]        rsp_column_bits
);

   // An accepted word keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   // A result word only appears while a word is in flight.
   a_reply_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while not busy");

   // After a result the block is free again, so the strobe is one cycle wide.
   a_reply_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("block still busy after result word");

   // A lit pixel comes from a column with at least one lit row.
   a_pixel_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_on |-> rsp_column_bits != 7'h00)
      else $error("lit pixel in an empty column");

endmodule

bind scrolling_text_matrix_renderer_top strm_checker u_strm_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_pixel_on     (rsp_pixel_on),
   .rsp_column_bits  (rsp_column_bits)
);

@@ dv/scrolling_text_matrix_renderer_check.sv @@
`timescale 1ns / 100ps
// Checker for the scrolling text matrix renderer: predicts each status word and compares it.
module scrolling_text_matrix_renderer_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [3:0]        req_operation,
   input  logic [3:0]        req_char_pos,
   input  logic [7:0]        req_char_code,
   input  logic [3:0]        req_text_length,
   input  logic              req_enable_value,
   input  logic signed [7:0] req_offset_value,
   input  logic [7:0]        req_pixel_row,
   input  logic [7:0]        req_pixel_col,
   input  logic              rsp_valid,
   input  logic              rsp_pixel_on,
   input  logic [6:0]        rsp_column_bits,
   input  logic              rsp_scroll_on,
   input  logic              rsp_test_on,
   input  logic signed [7:0] rsp_position,
   input  logic [3:0]        rsp_shown_length,
   input  logic              csr_we,
   input  logic signed [7:0] csr_wdata,
   output int                failures,
   output int                outstanding
);
   import strm_pkg::*;

   // One status word as the block reports it.
   typedef struct packed {
      logic       pixel_on;
      logic [6:0] column_bits;
      logic       scroll_on;
      logic       test_on;
      logic [7:0] position;
      logic [3:0] shown_length;
   } status_word_type;

   status_word_type status_q[$];
   int fail_count = 0;
   int pending_words = 0;

   // Shadow copy of the renderer state.
   logic [7:0] staged_text [MAX_CHARS];
   logic [7:0] shown_text [MAX_CHARS];
   logic [7:0] kept_text [MAX_CHARS];
   int shown_count;
   int kept_count;
   int scroll_at;
   bit scrolling;
   bit testing;
   int saved_at;
   bit saved_scrolling;
   int restart_at;

   // Font columns, first column in the top seven bits.
   logic [34:0] font [26];

   assign failures = fail_count;
   assign outstanding = pending_words;

   initial begin
      font[0]  = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      font[1]  = {7'h00, 7'h21, 7'h7F, 7'h01, 7'h00};
      font[2]  = {7'h23, 7'h45, 7'h49, 7'h51, 7'h22};
      font[3]  = {7'h22, 7'h41, 7'h49, 7'h49, 7'h36};
      font[4]  = {7'h0C, 7'h14, 7'h24, 7'h7F, 7'h04};
      font[5]  = {7'h72, 7'h51, 7'h51, 7'h51, 7'h4E};
      font[6]  = {7'h3E, 7'h49, 7'h49, 7'h49, 7'h06};
      font[7]  = {7'h40, 7'h40, 7'h47, 7'h48, 7'h70};
      font[8]  = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      font[9]  = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
      font[10] = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
      font[11] = {7'h00, 7'h00, 7'h08, 7'h00, 7'h00};
      font[12] = {7'h30, 7'h48, 7'h48, 7'h30, 7'h00};
      font[13] = {7'h7F, 7'h10, 7'h08, 7'h04, 7'h7F};
      font[14] = {7'h32, 7'h49, 7'h49, 7'h49, 7'h26};
      font[15] = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
      font[16] = {7'h7E, 7'h01, 7'h1E, 7'h01, 7'h7E};
      font[17] = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
      font[18] = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
      font[19] = {7'h40, 7'h20, 7'h1F, 7'h20, 7'h40};
      font[20] = {7'h1F, 7'h24, 7'h44, 7'h24, 7'h1F};
      font[21] = {7'h40, 7'h40, 7'h7F, 7'h40, 7'h40};
      font[22] = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
      font[23] = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
      font[24] = {7'h7C, 7'h02, 7'h01, 7'h02, 7'h7C};
      font[25] = {7'h7F, 7'h01, 7'h01, 7'h01, 7'h02};
   end

   // Glyph number of a character byte; bytes without a glyph fall back to the digit zero.
   function automatic int char_glyph(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      case (c)
         ":":         return 10;
         ".":         return 11;
         DEGREE_CODE: return 12;
         "N":         return 13;
         "S":         return 14;
         "E":         return 15;
         "W":         return 16;
         " ":         return 17;
         "D":         return 18;
         "Y":         return 19;
         "A":         return 20;
         "T":         return 21;
         "C":         return 22;
         "H":         return 23;
         "V":         return 24;
         "L":         return 25;
         default:     return 0;
      endcase
   endfunction

   // Lit rows of one display column at the current scroll position.
   function automatic logic [6:0] text_column(input int col);
      int idx;
      int ch;
      int sub;
      if (col >= MATRIX_COLS || shown_count == 0) return 7'h00;
      idx = scroll_at + col;
      if (idx < 0 || idx >= shown_count * CHAR_PITCH) return 7'h00;
      ch = idx / CHAR_PITCH;
      sub = idx % CHAR_PITCH;
      if (sub >= GLYPH_COLS || ch >= MAX_CHARS) return 7'h00;
      return font[char_glyph(shown_text[ch])][34 - 7 * sub -: 7] & ROW_MASK;
   endfunction

   task automatic commit_text(input int len);
      shown_text = staged_text;
      shown_count = (len > MAX_CHARS) ? MAX_CHARS : len;
   endtask

   task automatic restore_text();
      shown_text = kept_text;
      shown_count = kept_count;
   endtask

   task automatic clear_renderer();
      foreach (staged_text[i]) begin
         staged_text[i] = '0;
         shown_text[i] = '0;
         kept_text[i] = '0;
      end
      shown_count = 0;
      kept_count = 0;
      restart_at = int'(RESTART_RESET);
      scroll_at = restart_at;
      scrolling = 1'b0;
      testing = 1'b0;
      saved_at = 0;
      saved_scrolling = 1'b0;
   endtask

   // Apply the accepted word to the shadow state and work out the status it reports.
   task automatic render_step(output status_word_type s);
      logic [6:0] bits;
      logic pix;
      int next;
      bits = '0;
      pix = 1'b0;
      case (req_operation)
         OP_STAGE: begin
            if (req_char_pos < MAX_CHARS) staged_text[req_char_pos] = req_char_code;
         end
         OP_SET_RST: begin
            commit_text(req_text_length);
            if (shown_count > 0) begin
               scrolling = 1'b1;
               scroll_at = restart_at;
            end
         end
         OP_SET_KEEP: begin
            commit_text(req_text_length);
         end
         OP_TEST_ON: begin
            kept_text = shown_text;
            kept_count = shown_count;
            commit_text(req_text_length);
            testing = 1'b1;
            scrolling = 1'b1;
            scroll_at = restart_at;
         end
         OP_TEST_OFF: begin
            if (testing) begin
               testing = 1'b0;
               if (kept_count > 0) begin
                  restore_text();
                  scroll_at = restart_at;
               end
            end
         end
         OP_TICK: begin
            // A full pass reloads the position and ends any test message.
            if (shown_count > 0 && scrolling) begin
               next = scroll_at + 1;
               if (next >= shown_count * CHAR_PITCH) begin
                  scroll_at = restart_at;
                  if (testing) begin
                     testing = 1'b0;
                     if (kept_count > 0) restore_text();
                  end
               end else begin
                  scroll_at = (next > 127) ? 127 : next;
               end
            end
         end
         OP_ENABLE: begin
            scrolling = req_enable_value;
         end
         OP_SAVE: begin
            saved_at = scroll_at;
            saved_scrolling = scrolling;
         end
         OP_RESTORE: begin
            scroll_at = saved_at;
            scrolling = saved_scrolling;
         end
         OP_OFFSET: begin
            scroll_at = int'(req_offset_value);
         end
         OP_READ: begin
            bits = text_column(int'(req_pixel_col));
            if (req_pixel_row < MATRIX_ROWS && req_pixel_col < MATRIX_COLS) begin
               pix = bits[6 - req_pixel_row];
            end
         end
         default: begin
         end
      endcase
      s.pixel_on = pix;
      s.column_bits = bits;
      s.scroll_on = scrolling;
      s.test_on = testing;
      s.position = 8'(scroll_at);
      s.shown_length = 4'(shown_count);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Compare each strobed word with the oldest prediction, then predict the newly accepted word.
   always @(posedge clock) begin
      status_word_type want;
      status_word_type fresh;
      if (reset) begin
         clear_renderer();
         status_q.delete();
      end else begin
         if (rsp_valid) begin
            if (status_q.size() == 0) begin
               $error("status word strobed with no prediction waiting");
               fail_count++;
            end else begin
               want = status_q.pop_front();
               check_field("pixel_on", want.pixel_on, rsp_pixel_on);
               check_field("column_bits", want.column_bits, rsp_column_bits);
               check_field("scroll_on", want.scroll_on, rsp_scroll_on);
               check_field("test_on", want.test_on, rsp_test_on);
               check_field("position", $signed(want.position), rsp_position);
               check_field("shown_length", want.shown_length, rsp_shown_length);
            end
         end
         if (csr_we) restart_at = int'(csr_wdata);
         if (start && !busy) begin
            render_step(fresh);
            status_q.push_back(fresh);
         end
      end
      pending_words = status_q.size();
   end

endmodule

@@ dv/tb_scrolling_text_matrix_renderer_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the scrolling text matrix renderer: clock, reset, stimulus and verdict.
module tb_scrolling_text_matrix_renderer_top;
   import strm_pkg::*;

   localparam logic [3:0] OP_UNUSED = 4'd15;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [3:0]        req_operation = '0;
   logic [3:0]        req_char_pos = '0;
   logic [7:0]        req_char_code = '0;
   logic [3:0]        req_text_length = '0;
   logic              req_enable_value = 1'b0;
   logic signed [7:0] req_offset_value = '0;
   logic [7:0]        req_pixel_row = '0;
   logic [7:0]        req_pixel_col = '0;
   logic              rsp_valid;
   logic              rsp_pixel_on;
   logic [6:0]        rsp_column_bits;
   logic              rsp_scroll_on;
   logic              rsp_test_on;
   logic signed [7:0] rsp_position;
   logic [3:0]        rsp_shown_length;
   logic              csr_we = 1'b0;
   logic signed [7:0] csr_wdata = '0;

   int failures;
   int outstanding;
   int idle_pct = 0;

   always #5 clock = ~clock;

   scrolling_text_matrix_renderer_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_char_pos     (req_char_pos),
      .req_char_code    (req_char_code),
      .req_text_length  (req_text_length),
      .req_enable_value (req_enable_value),
      .req_offset_value (req_offset_value),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_on     (rsp_pixel_on),
      .rsp_column_bits  (rsp_column_bits),
      .rsp_scroll_on    (rsp_scroll_on),
      .rsp_test_on      (rsp_test_on),
      .rsp_position     (rsp_position),
      .rsp_shown_length (rsp_shown_length),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   scrolling_text_matrix_renderer_check u_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_char_pos     (req_char_pos),
      .req_char_code    (req_char_code),
      .req_text_length  (req_text_length),
      .req_enable_value (req_enable_value),
      .req_offset_value (req_offset_value),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_on     (rsp_pixel_on),
      .rsp_column_bits  (rsp_column_bits),
      .rsp_scroll_on    (rsp_scroll_on),
      .rsp_test_on      (rsp_test_on),
      .rsp_position     (rsp_position),
      .rsp_shown_length (rsp_shown_length),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   // Send one command word. The meaning of a and b depends on the operation;
   // fields the operation ignores carry random noise.
   task automatic issue(input logic [3:0] op, input int a, input int b);
      int gap;
      logic [3:0] cpos;
      logic [7:0] code;
      logic [3:0] len;
      logic       en;
      logic [7:0] offv;
      logic [7:0] row;
      logic [7:0] col;
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
      cpos = 4'($urandom);
      code = 8'($urandom);
      len = 4'($urandom);
      en = 1'($urandom);
      offv = 8'($urandom);
      row = 8'($urandom);
      col = 8'($urandom);
      case (op)
         OP_STAGE: begin
            cpos = 4'(a);
            code = 8'(b);
         end
         OP_SET_RST, OP_SET_KEEP, OP_TEST_ON: len = 4'(a);
         OP_ENABLE: en = 1'(a);
         OP_OFFSET: offv = 8'(a);
         OP_READ: begin
            row = 8'(a);
            col = 8'(b);
         end
         default: begin
         end
      endcase
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_char_pos <= cpos;
      req_char_code <= code;
      req_text_length <= len;
      req_enable_value <= en;
      req_offset_value <= offv;
      req_pixel_row <= row;
      req_pixel_col <= col;
      do @(posedge clock); while (busy);
   endtask

   // Wait until every status word is back, then write the restart offset.
   task automatic load_restart_offset(input int value);
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (6) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= 8'(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One random operation, or a short burst of ticks; count gives the words sent.
   task automatic random_operation(output int count);
      string charset;
      int pick;
      int len;
      int c;
      charset = "0123456789:.NSEWDYATCHVL ";
      pick = $urandom_range(0, 99);
      count = 1;
      len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 15);
      if (pick < 32) begin
         count = $urandom_range(1, 6);
         repeat (count) issue(OP_TICK, 0, 0);
      end else if (pick < 55) begin
         issue(OP_READ,
               ($urandom_range(0, 6) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 255),
               ($urandom_range(0, 6) != 0) ? $urandom_range(0, 33) : $urandom_range(0, 255));
      end else if (pick < 63) begin
         if ($urandom_range(0, 3) != 0) begin
            c = charset[$urandom_range(0, charset.len() - 1)];
         end else if ($urandom_range(0, 1) != 0) begin
            c = DEGREE_CODE;
         end else begin
            c = $urandom_range(0, 255);
         end
         issue(OP_STAGE, $urandom_range(0, 15), c);
      end else if (pick < 69) begin
         issue(OP_SET_RST, len, 0);
      end else if (pick < 72) begin
         issue(OP_SET_KEEP, len, 0);
      end else if (pick < 76) begin
         issue(OP_TEST_ON, len, 0);
      end else if (pick < 79) begin
         issue(OP_TEST_OFF, 0, 0);
      end else if (pick < 83) begin
         issue(OP_ENABLE, ($urandom_range(0, 4) != 0) ? 1 : 0, 0);
      end else if (pick < 87) begin
         issue(OP_SAVE, 0, 0);
      end else if (pick < 90) begin
         issue(OP_RESTORE, 0, 0);
      end else if (pick < 96) begin
         issue(OP_OFFSET,
               ($urandom_range(0, 2) != 0) ? $urandom_range(0, 40) - 20
                                           : $urandom_range(0, 255) - 128, 0);
      end else begin
         issue(4'($urandom_range(11, 15)), 0, 0);
      end
   endtask

   // Stimulus: directed words first, then six random phases with a new restart offset each.
   initial begin
      logic [7:0] first_text [15];
      int restart_values [6];
      int sent;
      int n;
      first_text = '{8'h00, 8'hFF, DEGREE_CODE, "N", "S", "E", "W", ":", ".",
                     "A", "T", "C", "H", "V", "L"};
      restart_values = '{-128, 127, -6, 0, 0, -1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Operations on empty text, then fill every staging slot once.
      issue(OP_READ, 0, 0);
      issue(OP_SET_RST, 0, 0);
      issue(OP_TICK, 0, 0);
      issue(OP_TEST_OFF, 0, 0);
      issue(OP_STAGE, 15, 8'hFF);
      for (int i = 0; i < 15; i++) issue(OP_STAGE, i, first_text[i]);

      // Full-length text, position extremes, a pass end and an empty test message.
      issue(OP_SET_KEEP, 15, 0);
      issue(OP_SAVE, 0, 0);
      issue(OP_SET_RST, 15, 0);
      issue(OP_OFFSET, 127, 0);
      issue(OP_TICK, 0, 0);
      issue(OP_OFFSET, -128, 0);
      issue(OP_READ, 255, 255);
      issue(OP_TEST_ON, 0, 0);
      issue(OP_TEST_OFF, 0, 0);
      issue(OP_RESTORE, 0, 0);
      issue(OP_UNUSED, 0, 0);

      for (int ph = 0; ph < 6; ph++) begin
         idle_pct = (ph < 2) ? 37 : ((ph < 4) ? 66 : 0);
         if (ph == 4) restart_values[ph] = $urandom_range(0, 30) - 25;
         load_restart_offset(restart_values[ph]);
         sent = 0;
         while (sent < 86) begin
            random_operation(n);
            sent += n;
         end
      end

      // Drain the remaining status words, then allow for the read latency.
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #3000000;
      $display("FAILURE");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/strm_pkg.sv
hdl/strm_ctrl.sv
hdl/strm_datapath.sv
hdl/scrolling_text_matrix_renderer_top.sv
hdl/strm_checker.sv
dv/scrolling_text_matrix_renderer_check.sv
dv/tb_scrolling_text_matrix_renderer_top.sv
